>>> sv/point_in_triangle_search_assert.svh
// Assertion macros for the point-in-triangle search block.
`ifndef POINT_IN_TRIANGLE_SEARCH_ASSERT_SVH
`define POINT_IN_TRIANGLE_SEARCH_ASSERT_SVH

`ifndef SYNTHESIS
`define PITS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("pits assertion failed");
`define PITS_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("pits assertion failed");
`else
`define PITS_ASSERT(lbl, prop)
`define PITS_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

>>> sv/pits_pkg.sv
`default_nettype none
package pits_pkg;

  typedef enum logic [1:0] {
    OP_LOAD_VERT = 2'd0,
    OP_LOAD_TRI  = 2'd1,
    OP_QUERY     = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CFG_MESH_READY = 2'd0,
    CFG_TRI_COUNT  = 2'd1
  } cfg_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_DONE = 2'd2
  } state_e;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] z;
  } vert_t;

  typedef struct packed {
    logic [9:0] a;
    logic [9:0] b;
    logic [9:0] c;
    logic       walk;
  } tri_t;

  typedef struct packed {
    logic        valid;
    logic        walk;
    logic        last;
    logic [10:0] idx;
  } meta_t;

  typedef struct packed {
    logic neg;
    logic pos;
  } flags_t;

endpackage
`default_nettype wire

>>> sv/point_in_triangle_search.sv
`default_nettype none
// Point lookup over a walkable triangle mesh. Load words (op 0 vertex, op 1 triangle) write
// one table entry and give no result. A query word scans triangle entries 0 to
// triangle_count-1 (at most MAX_TRIS) one per cycle through three parallel edge cells,
// and returns the first walkable triangle whose edge cross products do not mix signs;
// points on an edge and degenerate triangles count as inside. A hit ends the scan. The
// single triangle table read port feeds the five-stage fetch and cell chain. With
// mesh_ready low, or a count of zero, the query skips the scan and returns (found 0,
// index 0). Loads and a new query are taken while a result waits on the output.
// Coordinates are signed Q8.8 and all products exact.
module point_in_triangle_search #(
  parameter int MAX_VERTS = 1024,
  parameter int MAX_TRIS  = 1024
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [10:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         op_i,
  input  wire logic [9:0]         entry_index_i,
  input  wire logic signed [15:0] coord_x_i,
  input  wire logic signed [15:0] coord_z_i,
  input  wire logic [9:0]         corner_a_i,
  input  wire logic [9:0]         corner_b_i,
  input  wire logic [9:0]         corner_c_i,
  input  wire logic               can_walk_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    found_o,
  output logic [9:0]              hit_index_o
);
  import pits_pkg::*;

  `include "point_in_triangle_search_assert.svh"

  localparam int VAW = $clog2(MAX_VERTS);
  localparam int TAW = (MAX_TRIS > 1) ? $clog2(MAX_TRIS) : 1;

  logic        mesh_ready_q;
  logic [10:0] count_q;
  logic [10:0] count_lim;

  state_e      state_q, state_d;
  logic [10:0] cnt_q, cnt_d;
  logic [10:0] n_q, n_d;
  vert_t       point_q, point_d;
  logic        res_found_q, res_found_d;
  logic [9:0]  res_idx_q, res_idx_d;
  logic        out_valid_q, out_valid_d;
  logic        found_q, found_d;
  logic [9:0]  hit_q, hit_d;

  logic        in_acc;
  logic        issue;
  logic        scan_end;
  logic        hit;
  meta_t       meta_q [1:5];
  meta_t       meta_in;

  tri_t        tri_mem [MAX_TRIS];
  tri_t        tri_rd_q;
  logic [9:0]  corner [3];
  logic [2:0]  cv_q;
  vert_t       vrd [3];
  vert_t       vtx [3];
  flags_t      flags [3];
  logic        any_neg, any_pos;
  logic        vert_we;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mesh_ready_q <= 1'b0;
      count_q      <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MESH_READY: mesh_ready_q <= cfg_data_i[0];
        CFG_TRI_COUNT:  count_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign count_lim = (32'(count_q) > MAX_TRIS) ? 11'(MAX_TRIS) : count_q;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // table writes
  assign vert_we = in_acc && (op_e'(op_i) == OP_LOAD_VERT) &&
                   (32'(entry_index_i) < MAX_VERTS);

  always_ff @(posedge clk_i) begin
    if (in_acc && (op_e'(op_i) == OP_LOAD_TRI) && (32'(entry_index_i) < MAX_TRIS)) begin
      tri_mem[TAW'(entry_index_i)] <= '{a: corner_a_i, b: corner_b_i, c: corner_c_i,
                                         walk: can_walk_i};
    end
  end

  always_ff @(posedge clk_i) begin
    tri_rd_q <= tri_mem[TAW'(cnt_q)];
  end

  assign corner[0] = tri_rd_q.a;
  assign corner[1] = tri_rd_q.b;
  assign corner[2] = tri_rd_q.c;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      cv_q[i] <= (32'(corner[i]) < MAX_VERTS);
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_vert
    pits_vert_ram #(
      .DEPTH (MAX_VERTS),
      .AW    (VAW)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (vert_we),
      .waddr_i (VAW'(entry_index_i)),
      .wdata_i ('{x: coord_x_i, z: coord_z_i}),
      .raddr_i (VAW'(corner[g])),
      .rdata_o (vrd[g])
    );

    assign vtx[g] = cv_q[g] ? vrd[g] : '0;
  end

  for (genvar g = 0; g < 3; g++) begin : g_cell
    pits_edge_cell u_cell (
      .clk_i   (clk_i),
      .p_i     (point_q),
      .q_i     (vtx[g]),
      .r_i     (vtx[(g + 1) % 3]),
      .flags_o (flags[g])
    );
  end

  assign any_neg = flags[0].neg || flags[1].neg || flags[2].neg;
  assign any_pos = flags[0].pos || flags[1].pos || flags[2].pos;
  assign hit      = meta_q[5].valid && meta_q[5].walk && !(any_neg && any_pos);
  assign scan_end = (state_q == ST_SCAN) && meta_q[5].valid && (hit || meta_q[5].last);

  // tag pipeline; walk flag joins once the triangle word is read
  assign issue = (state_q == ST_SCAN) && (cnt_q != n_q);
  assign meta_in = '{valid: issue, walk: 1'b0, last: (cnt_q == n_q - 11'd1), idx: cnt_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 1; i <= 5; i++) begin
        meta_q[i] <= '0;
      end
    end else if (scan_end) begin
      for (int i = 1; i <= 5; i++) begin
        meta_q[i] <= '0;
      end
    end else begin
      meta_q[1] <= meta_in;
      meta_q[2] <= '{valid: meta_q[1].valid, walk: tri_rd_q.walk, last: meta_q[1].last,
                     idx: meta_q[1].idx};
      for (int i = 3; i <= 5; i++) begin
        meta_q[i] <= meta_q[i-1];
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    point_d     = point_q;
    res_found_d = res_found_q;
    res_idx_d   = res_idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    found_d     = found_q;
    hit_d       = hit_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (op_e'(op_i) == OP_QUERY)) begin
          point_d     = '{x: coord_x_i, z: coord_z_i};
          res_found_d = 1'b0;
          res_idx_d   = '0;
          cnt_d       = '0;
          n_d         = count_lim;
          if (mesh_ready_q && (count_lim != 11'd0)) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (issue) begin
          cnt_d = cnt_q + 11'd1;
        end
        if (scan_end) begin
          res_found_d = hit;
          res_idx_d   = hit ? meta_q[5].idx[9:0] : 10'd0;
          state_d     = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          found_d     = res_found_q;
          hit_d       = res_idx_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    point_q     <= point_d;
    res_found_q <= res_found_d;
    res_idx_q   <= res_idx_d;
    found_q     <= found_d;
    hit_q       <= hit_d;
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign hit_index_o = hit_q;

  `PITS_ASSERT(a_idle_drained, in_ready_o |-> !(meta_q[1].valid || meta_q[3].valid || meta_q[5].valid))
  `PITS_ASSERT(a_cnt_bound, (state_q == ST_SCAN) |-> (cnt_q <= n_q))
  `PITS_ASSERT_NEXT(a_end_done, scan_end, (state_q == ST_DONE) && !meta_q[5].valid)

endmodule
`default_nettype wire

>>> sv/pits_vert_ram.sv
`default_nettype none
module pits_vert_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [AW-1:0]   waddr_i,
  input  wire pits_pkg::vert_t wdata_i,
  input  wire logic [AW-1:0]   raddr_i,
  output pits_pkg::vert_t      rdata_o
);
  import pits_pkg::*;

  vert_t mem [DEPTH];
  vert_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> sv/pits_edge_cell.sv
`default_nettype none
module pits_edge_cell (
  input  wire logic            clk_i,
  input  wire pits_pkg::vert_t p_i,
  input  wire pits_pkg::vert_t q_i,
  input  wire pits_pkg::vert_t r_i,
  output pits_pkg::flags_t     flags_o
);
  import pits_pkg::*;

  logic signed [16:0] dprx_q, dqrz_q, dqrx_q, dprz_q;
  logic signed [33:0] prod1_q, prod2_q;
  logic signed [34:0] term;
  flags_t             flags_q;

  // edge term (p - r) x (q - r), one stage each for differences, products, sign
  always_ff @(posedge clk_i) begin
    dprx_q <= {p_i.x[15], p_i.x} - {r_i.x[15], r_i.x};
    dqrz_q <= {q_i.z[15], q_i.z} - {r_i.z[15], r_i.z};
    dqrx_q <= {q_i.x[15], q_i.x} - {r_i.x[15], r_i.x};
    dprz_q <= {p_i.z[15], p_i.z} - {r_i.z[15], r_i.z};
  end

  always_ff @(posedge clk_i) begin
    prod1_q <= dprx_q * dqrz_q;
    prod2_q <= dqrx_q * dprz_q;
  end

  assign term = {prod1_q[33], prod1_q} - {prod2_q[33], prod2_q};

  always_ff @(posedge clk_i) begin
    flags_q.neg <= term[34];
    flags_q.pos <= !term[34] && (term != 35'sd0);
  end

  assign flags_o = flags_q;

endmodule
`default_nettype wire
